// ===== rtl/smt_pkg.sv =====
// Shared types, constants and decode helpers for the multi-turn servo tracker.
package smt_pkg;

  localparam int unsigned ID_LIMIT = 253;
  localparam int unsigned ENTRIES  = ID_LIMIT + 1;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);

  localparam int unsigned TURN_SHIFT = 12;  // 4096 counts per turn
  localparam int unsigned SUM_W      = 16 + TURN_SHIFT + 1;

  localparam logic signed [15:0]      UNWRAP_LIMIT = 16'sd2048;
  localparam logic signed [SUM_W-1:0] ABS_HI       = SUM_W'(30719);
  localparam logic signed [SUM_W-1:0] ABS_LO       = -SUM_W'(30719);

  localparam logic [1:0] OP_FEEDBACK   = 2'd0;
  localparam logic [1:0] OP_OFFLINE    = 2'd1;
  localparam logic [1:0] OP_TURN_RESET = 2'd2;

  typedef struct packed {
    logic        started;
    logic        online;
    logic [15:0] last_pos;
    logic [15:0] turns;
    logic [15:0] multi_pos;
    logic [15:0] speed;
    logic [15:0] load;
    logic [7:0]  temp;
    logic [7:0]  volt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   wr_en;
    entry_t entry;
  } upd_t;

  // sign-magnitude word to two's complement; negative zero becomes zero
  function automatic logic [15:0] decode_sm(input logic [15:0] w);
    logic [15:0] mag;
    mag = {1'b0, w[14:0]};
    return w[15] ? (16'd0 - mag) : mag;
  endfunction

  function automatic logic [15:0] saturate_abs(input logic signed [SUM_W-1:0] v);
    logic [15:0] r;
    if (v > ABS_HI) begin
      r = ABS_HI[15:0];
    end else if (v < ABS_LO) begin
      r = ABS_LO[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/smt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smt_update.sv =====
// Entry update: position decode, turn unwrap, multi-turn combine and saturation.
module smt_update
  import smt_pkg::*;
(
  input  logic [1:0]  op_i,
  input  logic        in_range_i,
  input  entry_t      cur_i,
  input  logic [15:0] position_word_i,
  input  logic [15:0] speed_word_i,
  input  logic [15:0] load_word_i,
  input  logic [7:0]  volt_i,
  input  logic [7:0]  temp_i,
  output upd_t        upd_o
);

  logic [15:0]             pos;
  logic [15:0]             diff;
  logic signed [15:0]      delta;
  logic [15:0]             turns_nx;
  logic signed [SUM_W-1:0] comb_sum;
  logic signed [SUM_W-1:0] last_ext;

  assign pos   = decode_sm(position_word_i);
  assign diff  = pos - cur_i.last_pos;
  assign delta = $signed(diff);

  always_comb begin
    if (!cur_i.started) begin
      turns_nx = 16'd0;
    end else if (delta > UNWRAP_LIMIT) begin
      turns_nx = cur_i.turns - 16'd1;
    end else if (delta < -UNWRAP_LIMIT) begin
      turns_nx = cur_i.turns + 16'd1;
    end else begin
      turns_nx = cur_i.turns;
    end
  end

  assign comb_sum = $signed({turns_nx[15], turns_nx, TURN_SHIFT'(0)})
                  + $signed({{(SUM_W-16){pos[15]}}, pos});
  assign last_ext = $signed({{(SUM_W-16){cur_i.last_pos[15]}}, cur_i.last_pos});

  always_comb begin
    upd_o.entry = cur_i;
    upd_o.wr_en = 1'b0;
    if (in_range_i) begin
      case (op_i)
        OP_FEEDBACK: begin
          upd_o.wr_en           = 1'b1;
          upd_o.entry.started   = 1'b1;
          upd_o.entry.online    = 1'b1;
          upd_o.entry.last_pos  = pos;
          upd_o.entry.turns     = turns_nx;
          upd_o.entry.multi_pos = saturate_abs(comb_sum);
          upd_o.entry.speed     = decode_sm(speed_word_i);
          upd_o.entry.load      = decode_sm(load_word_i);
          upd_o.entry.volt      = volt_i;
          upd_o.entry.temp      = temp_i;
        end
        OP_OFFLINE: begin
          upd_o.wr_en        = 1'b1;
          upd_o.entry.online = 1'b0;
        end
        OP_TURN_RESET: begin
          upd_o.wr_en           = 1'b1;
          upd_o.entry.turns     = 16'd0;
          upd_o.entry.multi_pos = saturate_abs(last_ext);
        end
        default: begin
          upd_o.wr_en = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/servo_multi_turn_tracker_unit.sv =====
// Top level of the multi-turn servo tracker: request pipeline, entry table and result register.
//
// Requests enter on in_valid_i/in_stall_o; one result per request leaves on
// out_valid_o/out_stall_i. A request is taken at an edge with valid high and
// stall low. Each request names a servo ID; IDs above 253 change nothing and
// return only echo_id with id_in_range low.
// An accepted request waits in the middle stage until the result register can take it.
// Throughput: one request per cycle while the receiver does not stall. The table is a
// 254-entry RAM read at acceptance and written back as the request leaves the middle
// stage; a request to the entry that the previous request is writing takes the forwarded value.
// Reset clears the per-entry valid bits, so every entry reads as zero at once;
// there is no clearing sweep and requests are taken right after reset.
// When the receiver stalls, the result register holds, the middle stage fills
// and then in_stall_o rises; nothing is dropped or repeated.
module servo_multi_turn_tracker_unit
  import smt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         servo_id_i,
  input  logic [15:0]        position_word_i,
  input  logic [15:0]        speed_word_i,
  input  logic [15:0]        load_word_i,
  input  logic [7:0]         supply_voltage_i,
  input  logic [7:0]         temperature_reading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         echo_id_o,
  output logic               id_in_range_o,
  output logic               is_online_o,
  output logic signed [15:0] raw_position_o,
  output logic signed [15:0] absolute_position_o,
  output logic signed [15:0] turn_total_o,
  output logic signed [15:0] decoded_speed_o,
  output logic signed [15:0] decoded_load_o,
  output logic [7:0]         stored_voltage_o,
  output logic [7:0]         stored_temperature_o
);

  logic               in_acc;
  logic               in_range;
  logic               s1_adv;
  logic               fwd_hit;

  logic               s1_vld_q;
  logic [1:0]         s1_op_q;
  logic [7:0]         s1_id_q;
  logic               s1_inr_q;
  logic               s1_vbit_q;
  logic               s1_fwd_q;
  logic [15:0]        s1_pos_q;
  logic [15:0]        s1_spd_q;
  logic [15:0]        s1_load_q;
  logic [7:0]         s1_volt_q;
  logic [7:0]         s1_temp_q;
  entry_t             fwd_entry_q;

  logic [ENTRIES-1:0] vbit_q;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur;
  upd_t               upd;

  logic               out_vld_q;
  logic [7:0]         out_id_q;
  logic               out_inr_q;
  entry_t             out_entry_q;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (servo_id_i <= 8'(ID_LIMIT));
  // the request ahead writes this same entry at the edge we read it
  assign fwd_hit    = s1_adv && upd.wr_en && (s1_id_q == servo_id_i);

  smt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (s1_adv && upd.wr_en),
    .waddr_i (s1_id_q[IDX_W-1:0]),
    .wdata_i (upd.entry),
    .re_i    (in_acc && in_range),
    .raddr_i (servo_id_i[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (s1_fwd_q) begin
      cur = fwd_entry_q;
    end else if (s1_vbit_q) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  smt_update u_update (
    .op_i            (s1_op_q),
    .in_range_i      (s1_inr_q),
    .cur_i           (cur),
    .position_word_i (s1_pos_q),
    .speed_word_i    (s1_spd_q),
    .load_word_i     (s1_load_q),
    .volt_i          (s1_volt_q),
    .temp_i          (s1_temp_q),
    .upd_o           (upd)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_fwd_q  <= 1'b0;
      s1_vbit_q <= 1'b0;
      out_vld_q <= 1'b0;
      vbit_q    <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q  <= 1'b1;
        s1_fwd_q  <= fwd_hit;
        s1_vbit_q <= in_range ? vbit_q[servo_id_i[IDX_W-1:0]] : 1'b0;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (s1_adv && upd.wr_en) begin
        vbit_q[s1_id_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= operation_i;
      s1_id_q     <= servo_id_i;
      s1_inr_q    <= in_range;
      s1_pos_q    <= position_word_i;
      s1_spd_q    <= speed_word_i;
      s1_load_q   <= load_word_i;
      s1_volt_q   <= supply_voltage_i;
      s1_temp_q   <= temperature_reading_i;
      fwd_entry_q <= upd.entry;
    end
    if (s1_adv) begin
      out_id_q    <= s1_id_q;
      out_inr_q   <= s1_inr_q;
      out_entry_q <= s1_inr_q ? upd.entry : '0;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign echo_id_o            = out_id_q;
  assign id_in_range_o        = out_inr_q;
  assign is_online_o          = out_entry_q.online;
  assign raw_position_o       = $signed(out_entry_q.last_pos);
  assign absolute_position_o  = $signed(out_entry_q.multi_pos);
  assign turn_total_o         = $signed(out_entry_q.turns);
  assign decoded_speed_o      = $signed(out_entry_q.speed);
  assign decoded_load_o       = $signed(out_entry_q.load);
  assign stored_voltage_o     = out_entry_q.volt;
  assign stored_temperature_o = out_entry_q.temp;

endmodule
